// File: rtl/core/wildcard_byte_pattern_scan_assert.svh
// Assertion macros used by the wildcard byte pattern scan checker.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH

// Concurrent assertion that is switched off while reset is held.
`define WBPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define WBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/wbps_pkg.sv
// Package with the constants, types and register codes of the wildcard byte pattern scan.
`timescale 1ns / 1ps
package wbps_pkg;

  // Largest pattern the window supports and address width of the results.
  localparam int PATTERN_MAX = 16;
  localparam int ADDR_BITS   = 48;

  // Fixed field widths.
  localparam int REG_BYTES = 16;
  localparam int REG_W     = 64;
  localparam int PLEN_W    = 5;
  localparam int OFFS_W    = 16;
  localparam int OUT_W     = 48;
  localparam int IDX_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Derived sizes.
  localparam int LEN_CAP   = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
  localparam int LEN_W     = $clog2(LEN_CAP + 1);
  localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int SEQ_N     = WIN_DEPTH + 1;
  localparam int SEQ_IW    = $clog2(SEQ_N);

  localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

  localparam logic [OUT_W-1:0] ADDR_MASK =
    (ADDR_BITS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'((65'd1 << ADDR_BITS) - 65'd1);

  // Configuration register codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW     = 3'd0,
    CFG_PATTERN_HIGH    = 3'd1,
    CFG_PATTERN_LENGTH  = 3'd2,
    CFG_POSITION_OFFSET = 3'd3,
    CFG_BASE_ADDRESS    = 3'd4
  } cfg_idx_e;

  // Previous bytes of the region, entry 0 the most recent.
  typedef logic [WIN_DEPTH-1:0][7:0] window_t;

  // Outcome of the window compare for the byte at hand.
  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] addr;
  } match_t;

endpackage

// File: rtl/core/wbps_match.sv
// Parallel wildcard compare of the pattern against the byte window and match address sum.
`timescale 1ns / 1ps
module wbps_match
  import wbps_pkg::*;
(
  input  logic [7:0]        cur_byte_i,
  input  window_t           window_i,
  input  logic [REG_W-1:0]  pattern_low_i,
  input  logic [REG_W-1:0]  pattern_high_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic [IDX_W-1:0]  index_i,
  input  logic              may_end_i,
  input  logic [OFFS_W-1:0] offset_i,
  input  logic [OUT_W-1:0]  base_i,
  output match_t            match_o
);

  logic [7:0]              seq [SEQ_N];
  logic [2*REG_W-1:0]      pattern;
  logic                    all_ok;
  logic                    long_enough;
  logic [OUT_W-1:0]        start;
  logic [OUT_W-1:0]        offs_ext;

  assign pattern = {pattern_high_i, pattern_low_i};

  // Compare every pattern byte in use against the byte that sits at its place.
  always_comb begin
    logic [SEQ_IW-1:0] sel;
    logic [7:0]        pbyte;
    seq[0] = cur_byte_i;
    for (int i = 1; i < SEQ_N; i++) begin
      seq[i] = window_i[i-1];
    end
    all_ok = 1'b1;
    for (int k = 0; k < LEN_CAP; k++) begin
      sel   = SEQ_IW'(len_i) - SEQ_IW'(k) - SEQ_IW'(1);
      pbyte = pattern[8*k +: 8];
      if ((LEN_W'(k) < len_i) && (pbyte != WILDCARD_BYTE) && (pbyte != seq[sel])) begin
        all_ok = 1'b0;
      end
    end
  end

  // A match needs all of its bytes inside the region.
  assign long_enough = ({1'b0, index_i} + 33'd1) >= 33'(len_i);

  // Match start plus signed offset plus base, wrapped to the address width.
  assign start    = OUT_W'(index_i) + OUT_W'(1) - OUT_W'(len_i);
  assign offs_ext = {{(OUT_W-OFFS_W){offset_i[OFFS_W-1]}}, offset_i};

  assign match_o.hit  = (len_i != '0) && may_end_i && long_enough && all_ok;
  assign match_o.addr = (base_i + start + offs_ext) & ADDR_MASK;

endmodule

// File: rtl/core/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte pattern scan: input stage, scan state and result register.
//
//   Channel   Direction  Payload                         Handshake
//   s_axis    in         tdata: data_byte, tlast: last   tvalid / tready
//   m_axis    out        tdata: match_address            tvalid / tready
//   cfg       in         register index and write data   cfg_we_i only
//
// One byte is accepted per cycle unless the input stage stalls; its result is held in the result register for m_axis.
// The compare and the address sum lie between the input stage and the result register.
// A byte stalls in the input stage only when it matches while the result register is full
// and its result is not taken in the same cycle.
// Reset clears the scan state, the configuration and the valid flags; no clearing pass is needed.
// The byte marked last clears the window, index and skip count after its compare.
`timescale 1ns / 1ps
module wildcard_byte_pattern_scan
  import wbps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  // Input byte stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,   // last_byte
  // Match address stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata    // [47:0] match_address
);

  logic [REG_W-1:0]  pattern_low_q;
  logic [REG_W-1:0]  pattern_high_q;
  logic [PLEN_W-1:0] pattern_length_q;
  logic [OFFS_W-1:0] position_offset_q;
  logic [OUT_W-1:0]  base_address_q;

  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_last_q;

  window_t           window_q;
  window_t           window_d;
  logic [IDX_W-1:0]  index_q;
  logic [IDX_W-1:0]  index_d;
  logic [PLEN_W-1:0] skip_q;
  logic [PLEN_W-1:0] skip_d;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_addr_q;

  logic [LEN_W-1:0]  len_eff;
  match_t            match;
  logic              s_accept;
  logic              out_free;
  logic              s1_go;
  logic              emit;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q     <= '0;
      pattern_high_q    <= '0;
      pattern_length_q  <= '0;
      position_offset_q <= '0;
      base_address_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PATTERN_LOW:     pattern_low_q     <= cfg_wdata_i;
        CFG_PATTERN_HIGH:    pattern_high_q    <= cfg_wdata_i;
        CFG_PATTERN_LENGTH:  pattern_length_q  <= cfg_wdata_i[PLEN_W-1:0];
        CFG_POSITION_OFFSET: position_offset_q <= cfg_wdata_i[OFFS_W-1:0];
        CFG_BASE_ADDRESS:    base_address_q    <= cfg_wdata_i[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the largest supported pattern length saturate.
  assign len_eff = (pattern_length_q > PLEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                         : LEN_W'(pattern_length_q);

  wbps_match u_match (
    .cur_byte_i     (s1_byte_q),
    .window_i       (window_q),
    .pattern_low_i  (pattern_low_q),
    .pattern_high_i (pattern_high_q),
    .len_i          (len_eff),
    .index_i        (index_q),
    .may_end_i      (skip_q == '0),
    .offset_i       (position_offset_q),
    .base_i         (base_address_q),
    .match_o        (match)
  );

  // Handshake: the staged byte moves on unless it matches into a full result register.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_go         = s1_valid_q && (!match.hit || out_free);
  assign emit          = s1_go && match.hit;
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_byte_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
  end

  // Next scan state once the staged byte has been compared.
  always_comb begin
    window_d[0] = s1_byte_q;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      window_d[i] = window_q[i-1];
    end
    index_d = index_q + IDX_W'(1);
    skip_d  = (skip_q != '0) ? skip_q - PLEN_W'(1) : skip_q;
    if (match.hit) begin
      skip_d = PLEN_W'(len_eff) - PLEN_W'(1);
    end
    if (s1_last_q) begin
      window_d = '0;
      index_d  = '0;
      skip_d   = '0;
    end
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      index_q  <= '0;
      skip_q   <= '0;
    end else if (s1_go) begin
      window_q <= window_d;
      index_q  <= index_d;
      skip_q   <= skip_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_addr_q <= match.addr;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;

endmodule

// File: rtl/core/wbps_checker.sv
// Port-level checker for the wildcard byte pattern scan and its bind to the top level.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scan_assert.svh"
module wbps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // No result is shown while reset is held.
  `WBPS_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

  // A result register that goes from empty to full was fed by an earlier input transaction through the input stage.
  `WBPS_ASSERT(a_result_follows_input, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "result without a preceding input transaction")

  // The input side only stalls behind a stalled result.
  `WBPS_ASSERT(a_stall_only_on_output, clk_i, rst_ni, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input stalled while the output is free")

  // A stalled result stays in place.
  `WBPS_ASSERT(a_result_holds, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (.*);
